// ----- sv/rgb_led_chain_frame_generator_unit_macros.svh -----
// ---------------------------------------------------------------------------
// LED chain frame generator assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_CHAIN_FRAME_GENERATOR_UNIT_MACROS_SVH
`define RGB_LED_CHAIN_FRAME_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LEDFG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LEDFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ledfg_pkg.sv -----
// ---------------------------------------------------------------------------
// LED chain frame generator package
// Shared constants, codes, command and status types and helper functions.
// ---------------------------------------------------------------------------
package ledfg_pkg;

  localparam int LED_COUNT   = 15;
  localparam int GAMMA_DEPTH = 256;

  localparam logic [3:0] LAST_LED  = 4'd14;
  localparam logic [3:0] TOP_END   = 4'd11;
  localparam logic [3:0] NO_LED    = 4'd15;
  localparam logic [3:0] MAX_DIM   = 4'd8;
  localparam logic [7:0] HEAD_MARK = 8'hE0;

  // Item function codes
  localparam logic [2:0] FUNC_WR_PIXEL = 3'd0;
  localparam logic [2:0] FUNC_RD_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_WR_GAMMA = 3'd2;
  localparam logic [2:0] FUNC_REFRESH  = 3'd3;
  localparam logic [2:0] FUNC_POWER    = 3'd4;

  // Gamma channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIM_TOP    = 2'd0;
  localparam logic [1:0] CFG_DIM_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_POWER_SAVE = 2'd2;

  typedef enum logic [2:0] {
    SEL_START,
    SEL_LED,
    SEL_END,
    SEL_PIXEL,
    SEL_POWER
  } out_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       pix_we;
    logic       gam_we;
    logic       init_we;
    logic [7:0] init_addr;
    logic       gam_rd;
    logic       rd_item;
    logic       out_load;
    out_sel_t   out_sel;
    logic [3:0] led;
    logic [1:0] groups;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic lit;
  } ctl_status_t;

  // One step of the default curve: (x * (x + 1) + 255) >> 8
  function automatic logic [7:0] curve_step(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * (16'(x) + 16'd1) + 16'd255;
    return prod[15:8];
  endfunction

  // Mask of switched-off supply groups for a given group count
  function automatic logic [2:0] group_mask(input logic [1:0] groups);
    logic [2:0] mask;
    case (groups)
      2'd0:    mask = 3'd7;
      2'd1:    mask = 3'd6;
      2'd2:    mask = 3'd2;
      default: mask = 3'd0;
    endcase
    return mask;
  endfunction

endpackage

// ----- sv/ledfg_in_if.sv -----
// ---------------------------------------------------------------------------
// LED chain frame generator item channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface ledfg_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] led_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [1:0] gamma_channel;
  logic [7:0] gamma_index;
  logic [7:0] gamma_value;

  modport source (
    output valid, func, led_index, red_in, green_in, blue_in,
           gamma_channel, gamma_index, gamma_value,
    input  ready
  );

  modport sink (
    input  valid, func, led_index, red_in, green_in, blue_in,
           gamma_channel, gamma_index, gamma_value,
    output ready
  );
endinterface

// ----- sv/ledfg_out_if.sv -----
// ---------------------------------------------------------------------------
// LED chain frame generator result channel
// Valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
interface ledfg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_word;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [2:0]  power_mask;
  logic        power_applied;
  logic        wait_needed;
  logic        last;

  modport source (
    output valid, frame_word, red_out, green_out, blue_out,
           power_mask, power_applied, wait_needed, last,
    input  ready
  );

  modport sink (
    input  valid, frame_word, red_out, green_out, blue_out,
           power_mask, power_applied, wait_needed, last,
    output ready
  );
endinterface

// ----- sv/ledfg_ctrl.sv -----
// ---------------------------------------------------------------------------
// LED chain frame generator controller
// Sequences the gamma init sweep, item dispatch, refresh walk and power scan.
// ---------------------------------------------------------------------------
module ledfg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic [2:0]             item_func,
  output logic                   item_ready,
  output ledfg_pkg::ctl_cmd_t    cmd,
  input  ledfg_pkg::ctl_status_t status
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_INIT_END,
    ST_IDLE,
    ST_READ,
    ST_REF_START,
    ST_REF_LOOK,
    ST_REF_EMIT,
    ST_REF_END,
    ST_PWR_SCAN,
    ST_PWR_EMIT
  } state_t;

  state_t     state;
  logic [7:0] init_addr;
  logic [3:0] cnt;
  logic [1:0] groups;
  logic       accept;
  logic [1:0] scan_groups;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  // Group count implied by the first lit LED at the scan position
  always_comb begin
    if (cnt < ledfg_pkg::TOP_END) begin
      scan_groups = 2'd3;
    end else if (cnt == ledfg_pkg::LAST_LED) begin
      scan_groups = 2'd1;
    end else begin
      scan_groups = 2'd2;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.out_sel   = ledfg_pkg::SEL_START;
    cmd.init_addr = init_addr;
    cmd.led       = cnt;
    cmd.groups    = groups;
    case (state)
      ST_INIT: begin
        cmd.init_we = 1'b1;
      end
      ST_IDLE: begin
        cmd.load_item = accept;
        cmd.pix_we    = accept && (item_func == ledfg_pkg::FUNC_WR_PIXEL);
        cmd.gam_we    = accept && (item_func == ledfg_pkg::FUNC_WR_GAMMA);
      end
      ST_READ: begin
        cmd.rd_item  = 1'b1;
        cmd.out_sel  = ledfg_pkg::SEL_PIXEL;
        cmd.out_load = status.out_free;
      end
      ST_REF_START: begin
        cmd.out_sel  = ledfg_pkg::SEL_START;
        cmd.out_load = status.out_free;
      end
      ST_REF_LOOK: begin
        cmd.gam_rd = 1'b1;
      end
      ST_REF_EMIT: begin
        cmd.out_sel  = ledfg_pkg::SEL_LED;
        cmd.out_load = status.out_free;
      end
      ST_REF_END: begin
        cmd.out_sel  = ledfg_pkg::SEL_END;
        cmd.out_load = status.out_free;
      end
      ST_PWR_EMIT: begin
        cmd.out_sel  = ledfg_pkg::SEL_POWER;
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      cnt       <= '0;
      groups    <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          init_addr <= init_addr + 8'd1;
          if (init_addr == 8'hFF) begin
            state <= ST_INIT_END;
          end
        end
        ST_INIT_END: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            case (item_func)
              ledfg_pkg::FUNC_RD_PIXEL: state <= ST_READ;
              ledfg_pkg::FUNC_REFRESH:  state <= ST_REF_START;
              ledfg_pkg::FUNC_POWER: begin
                cnt   <= '0;
                state <= ST_PWR_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_REF_START: begin
          if (status.out_free) begin
            cnt   <= ledfg_pkg::LAST_LED;
            state <= ST_REF_LOOK;
          end
        end
        ST_REF_LOOK: begin
          state <= ST_REF_EMIT;
        end
        ST_REF_EMIT: begin
          if (status.out_free) begin
            if (cnt == 4'd0) begin
              state <= ST_REF_END;
            end else begin
              cnt   <= cnt - 4'd1;
              state <= ST_REF_LOOK;
            end
          end
        end
        ST_REF_END: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_PWR_SCAN: begin
          if (status.lit) begin
            groups <= scan_groups;
            state  <= ST_PWR_EMIT;
          end else if (cnt == ledfg_pkg::LAST_LED) begin
            groups <= 2'd0;
            state  <= ST_PWR_EMIT;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_PWR_EMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/ledfg_dpath.sv -----
// ---------------------------------------------------------------------------
// LED chain frame generator datapath
// Pixel store, gamma memories, config registers and the result register.
// ---------------------------------------------------------------------------
module ledfg_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  ledfg_pkg::ctl_cmd_t    cmd,
  output ledfg_pkg::ctl_status_t status,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  input  logic [3:0]             led_index,
  input  logic [7:0]             red_in,
  input  logic [7:0]             green_in,
  input  logic [7:0]             blue_in,
  input  logic [1:0]             gamma_channel,
  input  logic [7:0]             gamma_index,
  input  logic [7:0]             gamma_value,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [31:0]            frame_word,
  output logic [7:0]             red_out,
  output logic [7:0]             green_out,
  output logic [7:0]             blue_out,
  output logic [2:0]             power_mask,
  output logic                   power_applied,
  output logic                   wait_needed,
  output logic                   last
);

  logic [23:0] pixel_store [ledfg_pkg::LED_COUNT];
  logic [7:0]  gam_red   [ledfg_pkg::GAMMA_DEPTH];
  logic [7:0]  gam_green [ledfg_pkg::GAMMA_DEPTH];
  logic [7:0]  gam_blue  [ledfg_pkg::GAMMA_DEPTH];

  logic [3:0]  dim_top;
  logic [3:0]  dim_bottom;
  logic        power_save;
  logic [1:0]  powered_groups;
  logic [3:0]  item_led;

  logic [7:0]  init_k;
  logic [7:0]  init_addr_q;
  logic        init_we_q;

  logic [7:0]  gr_q;
  logic [7:0]  gg_q;
  logic [7:0]  gb_q;

  logic [3:0]  rd_addr;
  logic [23:0] rd_pixel;
  logic [3:0]  cfg_dim;
  logic [3:0]  led_dim;
  logic [7:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        wr_red;
  logic        wr_green;
  logic        wr_blue;

  // Pixel read port, shared by item reads, the refresh walk and the power scan
  assign rd_addr  = cmd.rd_item ? item_led : cmd.led;
  assign rd_pixel = (rd_addr == ledfg_pkg::NO_LED) ? 24'd0 : pixel_store[rd_addr];
  assign led_dim  = (cmd.led < ledfg_pkg::TOP_END) ? dim_top : dim_bottom;

  assign status.lit      = (led_dim != 4'd0) && (rd_pixel != 24'd0);
  assign status.out_free = !out_valid || out_ready;

  assign cfg_dim = (cfg_data > ledfg_pkg::MAX_DIM) ? ledfg_pkg::MAX_DIM : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_top    <= 4'd1;
      dim_bottom <= 4'd8;
      power_save <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ledfg_pkg::CFG_DIM_TOP:    dim_top    <= cfg_dim;
        ledfg_pkg::CFG_DIM_BOTTOM: dim_bottom <= cfg_dim;
        ledfg_pkg::CFG_POWER_SAVE: power_save <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ledfg_pkg::LED_COUNT; i++) begin
        pixel_store[i] <= '0;
      end
    end else if (cmd.pix_we && (led_index != ledfg_pkg::NO_LED)) begin
      pixel_store[led_index] <= {red_in, green_in, blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_led <= led_index;
    end
  end

  // Default curve: first step registered, second applied at the memory write
  always_ff @(posedge clk) begin
    if (rst) begin
      init_we_q <= 1'b0;
    end else begin
      init_we_q <= cmd.init_we;
    end
    init_k      <= ledfg_pkg::curve_step(cmd.init_addr);
    init_addr_q <= cmd.init_addr;
  end

  always_comb begin
    if (init_we_q) begin
      wr_addr  = init_addr_q;
      wr_data  = ledfg_pkg::curve_step(init_k);
      wr_red   = 1'b1;
      wr_green = 1'b1;
      wr_blue  = 1'b1;
    end else begin
      wr_addr  = gamma_index;
      wr_data  = gamma_value;
      wr_red   = cmd.gam_we && (gamma_channel == ledfg_pkg::CH_RED);
      wr_green = cmd.gam_we && (gamma_channel == ledfg_pkg::CH_GREEN);
      wr_blue  = cmd.gam_we && (gamma_channel == ledfg_pkg::CH_BLUE);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_red) begin
      gam_red[wr_addr] <= wr_data;
    end
    if (cmd.gam_rd) begin
      gr_q <= gam_red[rd_pixel[23:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_green) begin
      gam_green[wr_addr] <= wr_data;
    end
    if (cmd.gam_rd) begin
      gg_q <= gam_green[rd_pixel[15:8]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_blue) begin
      gam_blue[wr_addr] <= wr_data;
    end
    if (cmd.gam_rd) begin
      gb_q <= gam_blue[rd_pixel[7:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      powered_groups <= '0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      if ((cmd.out_sel == ledfg_pkg::SEL_POWER) && power_save &&
          (cmd.groups != powered_groups)) begin
        powered_groups <= cmd.groups;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end

    if (cmd.out_load) begin
      frame_word    <= '0;
      red_out       <= '0;
      green_out     <= '0;
      blue_out      <= '0;
      power_mask    <= '0;
      power_applied <= 1'b0;
      wait_needed   <= 1'b0;
      last          <= 1'b0;
      case (cmd.out_sel)
        ledfg_pkg::SEL_START: begin
        end
        ledfg_pkg::SEL_LED: begin
          frame_word <= {ledfg_pkg::HEAD_MARK | {4'd0, led_dim}, gb_q, gg_q, gr_q};
        end
        ledfg_pkg::SEL_END: begin
          frame_word <= '1;
          last       <= 1'b1;
        end
        ledfg_pkg::SEL_PIXEL: begin
          red_out   <= rd_pixel[23:16];
          green_out <= rd_pixel[15:8];
          blue_out  <= rd_pixel[7:0];
          last      <= 1'b1;
        end
        ledfg_pkg::SEL_POWER: begin
          last <= 1'b1;
          if (power_save && (cmd.groups != powered_groups)) begin
            power_mask    <= ledfg_pkg::group_mask(cmd.groups);
            power_applied <= 1'b1;
            wait_needed   <= (powered_groups < cmd.groups);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/rgb_led_chain_frame_generator_unit.sv -----
// ---------------------------------------------------------------------------
// RGB LED chain frame generator
// Pixel and gamma store with frame word generation for a serial LED chain.
// ---------------------------------------------------------------------------
// Usage:
//   items   - command transactions: write/read pixel, write gamma entry,
//             refresh the chain, evaluate supply groups. One item at a time.
//   results - result transactions from a single output register; last marks
//             the final word of an item. Writes produce no result.
//   cfg_*   - register writes (dim_top, dim_bottom, power_save), taken any
//             cycle cfg_we is high; write them only while the block is idle.
// Sequencing (receiver always ready):
//   a write completes in the idle state; a pixel read loads its result into
//   the output register from ST_READ, which then returns to idle.
//   A refresh delivers 17 words, start, one per LED and end: each LED frame
//   costs a pixel fetch and a registered gamma memory read (ST_REF_LOOK, then
//   ST_REF_EMIT). A power evaluation scans the pixel store one LED a cycle.
// Reset: pixels clear, registers take their defaults, and a sweep of all 256
//   gamma addresses loads the default curve in all three tables; items wait for it.
// Stall: when results.ready is low the current word holds in the output
//   register and the sequence pauses; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "rgb_led_chain_frame_generator_unit_macros.svh"

module rgb_led_chain_frame_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  ledfg_in_if.sink    items,
  ledfg_out_if.source results
);

  ledfg_pkg::ctl_cmd_t    cmd;
  ledfg_pkg::ctl_status_t status;
  logic                   item_ready;
  logic                   idle_pending;
  logic                   mid_word;
  logic                   side_clear;
  logic                   refresh_accept;

  // Hold item acceptance to the controller's idle state
  assign items.ready = item_ready;

  // Controller: init sweep, dispatch, refresh walk, power scan
  ledfg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_func  (items.func),
    .item_ready (item_ready),
    .cmd        (cmd),
    .status     (status)
  );

  // Datapath: stores, gamma lookups and the result register
  ledfg_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .led_index     (items.led_index),
    .red_in        (items.red_in),
    .green_in      (items.green_in),
    .blue_in       (items.blue_in),
    .gamma_channel (items.gamma_channel),
    .gamma_index   (items.gamma_index),
    .gamma_value   (items.gamma_value),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .frame_word    (results.frame_word),
    .red_out       (results.red_out),
    .green_out     (results.green_out),
    .blue_out      (results.blue_out),
    .power_mask    (results.power_mask),
    .power_applied (results.power_applied),
    .wait_needed   (results.wait_needed),
    .last          (results.last)
  );

  assign idle_pending   = items.ready && results.valid;
  assign mid_word       = results.valid && !results.last;
  assign side_clear     = (results.red_out == 8'd0) && (results.green_out == 8'd0) &&
                          (results.blue_out == 8'd0) && (results.power_mask == 3'd0);
  assign refresh_accept = items.valid && items.ready &&
                          (items.func == ledfg_pkg::FUNC_REFRESH);

  // While idle, only a finished item's final word can be waiting
  `LEDFG_ASSERT_SAME(a_idle_holds_last, idle_pending, results.last, "idle with partial refresh")

  // The gamma init pass blocks items right after reset
  `LEDFG_ASSERT_SAME(a_init_blocks, $past(rst), !items.ready, "item accepted in gamma init")

  // Words inside a refresh carry only the frame field
  `LEDFG_ASSERT_SAME(a_mid_refresh_clean, mid_word, side_clear, "stray data in refresh word")

  // Accepting a refresh starts a busy sequence
  `LEDFG_ASSERT_NEXT(a_refresh_busy, refresh_accept, !items.ready, "ready after refresh")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// RGB LED chain frame generator testbench
// Drives pixel, gamma, refresh and power items into the unit and checks every
// result word against a shadow copy of the pixel store, the gamma tables and
// the supply group state. A short table of directed items comes first. Random
// items follow, run in phases with different register settings, idle
// patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ledfg_pkg::*;

  // Codes the package leaves unnamed: spare functions, the dead gamma channel
  // and the register index past the last one.
  localparam logic [2:0] FUNC_RSVD5  = 3'd5;
  localparam logic [2:0] FUNC_RSVD7  = 3'd7;
  localparam logic [1:0] CH_NONE     = 2'd3;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  localparam int HOLD_CYCLES   = 400;   // receiver hold-off in the pressure phase
  localparam int SETTLE_CYCLES = 40;    // longer than a refresh or a power scan
  localparam int IDLE_LIMIT    = 6000;  // cycles without any transaction
  localparam int ITEMS_PER_PHASE = 56;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] chan;
    logic [7:0] gidx;
    logic [7:0] gval;
  } led_cmd_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  power_mask;
    logic        power_applied;
    logic        wait_needed;
    logic        last;
  } led_result_t;

  typedef struct packed {
    led_cmd_t    cmd;
    logic        typed;      // expected result written into the table
    logic [23:0] typed_rgb;  // pixel read back, or zero for a power row
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  ledfg_in_if  in_ch ();
  ledfg_out_if out_ch ();

  rgb_led_chain_frame_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (in_ch),
    .results   (out_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the block state
  logic [23:0] shadow_pixels [LED_COUNT];
  logic [7:0]  shadow_gamma  [3][GAMMA_DEPTH];
  logic [1:0]  shadow_groups;
  logic [3:0]  shadow_dim_top;
  logic [3:0]  shadow_dim_bottom;
  logic        shadow_power_save;

  led_result_t owed_results [$];
  stim_row_t   directed_rows [$];

  int errors = 0;
  int sender_pct = 0;   // chance in a hundred that the sender idles a cycle
  int recv_pct = 0;     // chance in a hundred that the receiver stalls a cycle
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Brightness of the half an LED belongs to
  function automatic logic [3:0] dim_for(input int led);
    return (led < int'(TOP_END)) ? shadow_dim_top : shadow_dim_bottom;
  endfunction

  // Work out the result words of one accepted item and update the shadow.
  task automatic apply_led_command(input led_cmd_t c);
    led_result_t r;
    logic [23:0] p;
    logic [7:0]  head;
    logic [1:0]  groups_now;
    bit          found;
    r = '0;
    case (c.func)
      FUNC_WR_PIXEL: begin
        if (c.led < NO_LED) shadow_pixels[c.led] = {c.red, c.green, c.blue};
      end
      FUNC_RD_PIXEL: begin
        p = (c.led < NO_LED) ? shadow_pixels[c.led] : 24'd0;
        r.red   = p[23:16];
        r.green = p[15:8];
        r.blue  = p[7:0];
        r.last  = 1'b1;
        owed_results.push_back(r);
      end
      FUNC_WR_GAMMA: begin
        if (c.chan != CH_NONE) shadow_gamma[c.chan][c.gidx] = c.gval;
      end
      FUNC_REFRESH: begin
        // Start frame, LEDs from the far end down to 0, then the end frame
        owed_results.push_back(r);
        for (int i = LED_COUNT - 1; i >= 0; i--) begin
          p = shadow_pixels[i];
          head = HEAD_MARK | {4'd0, dim_for(i)};
          r = '0;
          r.frame_word = {head, shadow_gamma[CH_BLUE][p[7:0]],
                          shadow_gamma[CH_GREEN][p[15:8]],
                          shadow_gamma[CH_RED][p[23:16]]};
          owed_results.push_back(r);
        end
        r = '0;
        r.frame_word = 32'hFFFF_FFFF;
        r.last = 1'b1;
        owed_results.push_back(r);
      end
      FUNC_POWER: begin
        r.last = 1'b1;
        if (shadow_power_save) begin
          groups_now = 2'd0;
          found = 1'b0;
          for (int i = 0; i < LED_COUNT; i++) begin
            if (!found && dim_for(i) != 4'd0 && shadow_pixels[i] != 24'd0) begin
              found = 1'b1;
              if (i == int'(LAST_LED))     groups_now = 2'd1;
              else if (i >= int'(TOP_END)) groups_now = 2'd2;
              else                         groups_now = 2'd3;
            end
          end
          if (groups_now != shadow_groups) begin
            case (groups_now)
              2'd0:    r.power_mask = 3'd7;
              2'd1:    r.power_mask = 3'd6;
              2'd2:    r.power_mask = 3'd2;
              default: r.power_mask = 3'd0;
            endcase
            r.power_applied = 1'b1;
            r.wait_needed   = (shadow_groups < groups_now);
            shadow_groups   = groups_now;
          end
        end
        owed_results.push_back(r);
      end
      default: ;  // spare codes are dropped without a result
    endcase
  endtask

  function automatic led_cmd_t random_cmd();
    led_cmd_t c;
    c.func  = 3'($urandom_range(0, 7));
    c.led   = 4'($urandom_range(0, 15));
    c.red   = 8'($urandom_range(0, 255));
    c.green = 8'($urandom_range(0, 255));
    c.blue  = 8'($urandom_range(0, 255));
    c.chan  = 2'($urandom_range(0, 3));
    c.gidx  = 8'($urandom_range(0, 255));
    c.gval  = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void add_row(input logic [2:0] func, input logic [3:0] led,
                                  input logic [23:0] rgb, input logic [1:0] chan,
                                  input logic [7:0] gidx, input logic [7:0] gval,
                                  input logic typed, input logic [23:0] typed_rgb);
    stim_row_t row;
    row.cmd = '{func, led, rgb[23:16], rgb[15:8], rgb[7:0], chan, gidx, gval};
    row.typed = typed;
    row.typed_rgb = typed_rgb;
    directed_rows.push_back(row);
  endfunction

  // Offer one item, after a random idle gap, and hold it until accepted.
  // Keep valid high across back-to-back items so it is never dropped and
  // raised in the same step.
  task automatic send_cmd(input led_cmd_t c, input logic typed,
                          input logic [23:0] typed_rgb);
    int gap;
    led_result_t r;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < sender_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= c.func;
    in_ch.led_index     <= c.led;
    in_ch.red_in        <= c.red;
    in_ch.green_in      <= c.green;
    in_ch.blue_in       <= c.blue;
    in_ch.gamma_channel <= c.chan;
    in_ch.gamma_index   <= c.gidx;
    in_ch.gamma_value   <= c.gval;
    do @(posedge clk); while (!in_ch.ready);
    // Typed rows are reads or a power check that leaves the state alone,
    // so the shadow needs no update for them.
    if (typed) begin
      r = '0;
      {r.red, r.green, r.blue} = typed_rgb;
      r.last = 1'b1;
      owed_results.push_back(r);
    end else begin
      apply_led_command(c);
    end
  endtask

  // Random traffic. A quarter of it is a power scene: clear the LEDs below a
  // chosen one, light that one, then evaluate the supply groups, so that
  // every group count gets reached.
  task automatic send_random(input int count);
    int sent;
    int pick;
    int target;
    led_cmd_t c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      c = random_cmd();
      if (pick < 25) begin
        target = $urandom_range(0, LED_COUNT);
        for (int j = 0; j < target; j++) begin
          c = random_cmd();
          c.func = FUNC_WR_PIXEL;
          c.led = 4'(j);
          {c.red, c.green, c.blue} = 24'd0;
          send_cmd(c, 1'b0, 24'd0);
          sent++;
        end
        if (target < LED_COUNT) begin
          c = random_cmd();
          c.func = FUNC_WR_PIXEL;
          c.led = 4'(target);
          if ({c.red, c.green, c.blue} == 24'd0) c.blue = 8'd1;
          send_cmd(c, 1'b0, 24'd0);
          sent++;
        end
        c = random_cmd();
        c.func = FUNC_POWER;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else if (pick < 50) begin
        c.func = FUNC_WR_PIXEL;
        if ($urandom_range(0, 9) < 3) {c.red, c.green, c.blue} = 24'd0;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else if (pick < 60) begin
        c.func = FUNC_RD_PIXEL;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else if (pick < 72) begin
        c.func = FUNC_WR_GAMMA;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else if (pick < 82) begin
        c.func = FUNC_REFRESH;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else if (pick < 95) begin
        c.func = FUNC_POWER;
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end else begin
        // Spare code, dropped by the block
        c.func = 3'($urandom_range(int'(FUNC_RSVD5), int'(FUNC_RSVD7)));
        send_cmd(c, 1'b0, 24'd0);
        sent++;
      end
    end
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the three registers back to back, optionally also the spare index,
  // and follow each write in the shadow. Lower the write enable only once.
  task automatic load_settings(input logic [3:0] top, input logic [3:0] bottom,
                               input logic [3:0] save, input logic spare);
    logic [1:0] idx [4];
    logic [3:0] val [4];
    logic [3:0] sat;
    int n;
    idx[0] = CFG_DIM_TOP;    val[0] = top;
    idx[1] = CFG_DIM_BOTTOM; val[1] = bottom;
    idx[2] = CFG_POWER_SAVE; val[2] = save;
    idx[3] = CFG_SPARE;      val[3] = 4'hF;
    n = spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      sat = (val[k] > MAX_DIM) ? MAX_DIM : val[k];
      case (idx[k])
        CFG_DIM_TOP:    shadow_dim_top    = sat;
        CFG_DIM_BOTTOM: shadow_dim_bottom = sat;
        CFG_POWER_SAVE: shadow_power_save = val[k][0];
        default: ;  // spare index writes nothing
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off counted here on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  // Result checker: compare each result transaction with the oldest owed one.
  always @(posedge clk) begin
    led_result_t got;
    led_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.frame_word, out_ch.red_out, out_ch.green_out, out_ch.blue_out,
              out_ch.power_mask, out_ch.power_applied, out_ch.wait_needed,
              out_ch.last};
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result frame_word", got.frame_word, 32'd0);
      end else begin
        want = owed_results.pop_front();
        if (got.frame_word !== want.frame_word)
          report_mismatch("frame_word", got.frame_word, want.frame_word);
        if (got.red !== want.red)
          report_mismatch("red_out", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
          report_mismatch("green_out", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
          report_mismatch("blue_out", 32'(got.blue), 32'(want.blue));
        if (got.power_mask !== want.power_mask)
          report_mismatch("power_mask", 32'(got.power_mask), 32'(want.power_mask));
        if (got.power_applied !== want.power_applied)
          report_mismatch("power_applied", 32'(got.power_applied),
                          32'(want.power_applied));
        if (got.wait_needed !== want.wait_needed)
          report_mismatch("wait_needed", 32'(got.wait_needed), 32'(want.wait_needed));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[rgb_led_chain_frame_generator_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int k1;
    int g1;
    // Hold every input at a known value from time zero
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_DIM_TOP;
    cfg_data = 4'd0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WR_PIXEL;
    in_ch.led_index = 4'd0;
    in_ch.red_in = 8'd0;
    in_ch.green_in = 8'd0;
    in_ch.blue_in = 8'd0;
    in_ch.gamma_channel = CH_RED;
    in_ch.gamma_index = 8'd0;
    in_ch.gamma_value = 8'd0;

    // Shadow state after reset: dark pixels, default curve (curve step applied twice)
    for (int i = 0; i < LED_COUNT; i++) shadow_pixels[i] = 24'd0;
    for (int i = 0; i < GAMMA_DEPTH; i++) begin
      k1 = (i * (i + 1) + 255) >> 8;
      g1 = (k1 * (k1 + 1) + 255) >> 8;
      for (int ch = 0; ch < 3; ch++) shadow_gamma[ch][i] = 8'(g1);
    end
    shadow_groups = 2'd0;
    shadow_dim_top = 4'd1;
    shadow_dim_bottom = 4'd8;
    shadow_power_save = 1'b1;

    // Directed table. Rows with a typed result are reads and the power check
    // straight after reset; all others go through the shadow.
    add_row(FUNC_RD_PIXEL, 4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b1, 24'h000000);
    add_row(FUNC_POWER,    4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b1, 24'h000000);
    add_row(FUNC_REFRESH,  4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_WR_PIXEL, 4'd0,  24'hFFFFFF, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_RD_PIXEL, 4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b1, 24'hFFFFFF);
    add_row(FUNC_WR_PIXEL, LAST_LED, 24'h000001, CH_RED, 8'h00, 8'h00, 1'b0, 24'h000000);
    // The index past the last pixel: write dropped, read gives zero
    add_row(FUNC_WR_PIXEL, NO_LED, 24'hFFFFFF, CH_RED,  8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_RD_PIXEL, NO_LED, 24'h000000, CH_RED,  8'h00, 8'h00, 1'b1, 24'h000000);
    add_row(FUNC_WR_GAMMA, 4'd0,  24'h000000, CH_RED,   8'h00, 8'hFF, 1'b0, 24'h000000);
    add_row(FUNC_WR_GAMMA, 4'd0,  24'h000000, CH_RED,   8'hFF, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_WR_GAMMA, 4'd0,  24'h000000, CH_GREEN, 8'hFF, 8'hA5, 1'b0, 24'h000000);
    add_row(FUNC_WR_GAMMA, 4'd0,  24'h000000, CH_BLUE,  8'h01, 8'hFF, 1'b0, 24'h000000);
    // Dead gamma channel: the write is dropped
    add_row(FUNC_WR_GAMMA, 4'd0,  24'h000000, CH_NONE,  8'hFF, 8'h5A, 1'b0, 24'h000000);
    add_row(FUNC_REFRESH,  4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_POWER,    4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    // Spare function codes give no result
    add_row(FUNC_RSVD5,    4'd3,  24'h123456, CH_BLUE,  8'h10, 8'h20, 1'b0, 24'h000000);
    add_row(FUNC_RSVD7,    4'd7,  24'hABCDEF, CH_NONE,  8'hF0, 8'h0F, 1'b0, 24'h000000);
    add_row(FUNC_WR_PIXEL, 4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_POWER,    4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_WR_PIXEL, TOP_END, 24'h800000, CH_RED, 8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_POWER,    4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);
    add_row(FUNC_RD_PIXEL, LAST_LED, 24'h000000, CH_RED, 8'h00, 8'h00, 1'b1, 24'h000001);
    add_row(FUNC_REFRESH,  4'd0,  24'h000000, CH_RED,   8'h00, 8'h00, 1'b0, 24'h000000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults, no idling; the first item waits out the gamma load
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].typed_rgb);
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    // Top brightness saturates, bottom off, spare index written; sender idles
    load_settings(4'hF, 4'h0, 4'h1, 1'b1);
    sender_pct = 66;
    recv_pct = 0;
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    // Top off, bottom saturates, power saving off; receiver stalls
    load_settings(4'h0, 4'h9, 4'hE, 1'b0);
    sender_pct = 0;
    recv_pct = 66;
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    // Both halves at full brightness, power saving back on; both sides idle
    load_settings(MAX_DIM, MAX_DIM, 4'h1, 1'b0);
    sender_pct = 19;
    recv_pct = 19;
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    // Hold the receiver off while the sender keeps offering items
    load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 4'hF, 1'b0);
    sender_pct = 0;
    recv_pct = 0;
    hold_req = 1'b1;
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    // Random settings, both sides idle
    load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 1'b1);
    sender_pct = 19;
    recv_pct = 19;
    send_random(ITEMS_PER_PHASE);
    finish_phase();

    if (errors == 0 && owed_results.size() == 0) begin
      $display("[rgb_led_chain_frame_generator_unit] OK");
    end else begin
      $display("[rgb_led_chain_frame_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
